// File: sv/bpc_pkg.sv
// Package for the button press classifier: key phase codes, register
// indexes, reset values and the per-key event struct.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

    // Hold counter
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Key phase codes
    localparam int PH_W = 2;
    localparam logic [PH_W-1:0] PH_RELEASED = 2'd0;
    localparam logic [PH_W-1:0] PH_PUSHED   = 2'd1;
    localparam logic [PH_W-1:0] PH_LONG     = 2'd2;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW_MASK  = 1'd1;

    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd100;
    localparam logic [31:0]      ACTIVE_LOW_MASK_RST  = 32'd6;

    // Events one key reports in one tick
    typedef struct packed {
        logic press;
        logic long_press;
        logic short_release;
        logic long_release;
    } key_evt_t;

endpackage

// File: sv/bpc_lane.sv
// One key lane: phase and hold counter state, events for the current tick.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_lane
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,          // tick beat accepted
    input  logic                      level,        // raw pin level
    input  logic                      active_low,   // polarity bit
    input  logic [bpc_pkg::CNT_W-1:0] long_ticks,   // long press threshold
    output bpc_pkg::key_evt_t         evt
);

    logic [bpc_pkg::PH_W-1:0]  phase_reg;
    logic [bpc_pkg::PH_W-1:0]  phase_next;
    logic [bpc_pkg::CNT_W-1:0] count_reg;
    logic [bpc_pkg::CNT_W-1:0] count_next;
    logic [bpc_pkg::CNT_W-1:0] count_inc;
    logic                      pressed;

    assign pressed   = level ^ active_low;
    // saturating increment
    assign count_inc = (count_reg != bpc_pkg::CNT_MAX) ? count_reg + 1'b1 : count_reg;

    // Phase transitions and events
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        evt        = '0;
        case (phase_reg)
            bpc_pkg::PH_RELEASED:
            begin
                if (pressed)
                begin
                    count_next = count_inc;
                    if (count_inc != '0)
                    begin
                        evt.press  = 1'b1;
                        phase_next = bpc_pkg::PH_PUSHED;
                    end
                end
            end
            bpc_pkg::PH_PUSHED:
            begin
                if (pressed)
                begin
                    count_next = count_inc;
                    if (count_inc > long_ticks)
                    begin
                        evt.long_press = 1'b1;
                        phase_next     = bpc_pkg::PH_LONG;
                    end
                end
                else
                begin
                    evt.short_release = 1'b1;
                    phase_next        = bpc_pkg::PH_RELEASED;
                    count_next        = '0;
                end
            end
            default:
            begin
                // long phase; the unused code behaves the same
                if (!pressed)
                begin
                    evt.long_release = 1'b1;
                    phase_next       = bpc_pkg::PH_RELEASED;
                    count_next       = '0;
                end
            end
        endcase
    end

    // State update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bpc_pkg::PH_RELEASED;
            count_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/bpc_merge.sv
// Merge stage: gathers lane events into four masks and holds the result beat.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_merge #(
    parameter int NUM_KEYS = 3,
    parameter int OUT_W    = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpc_pkg::key_evt_t    evt [NUM_KEYS],
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_W-1:0]     out_data
);

    logic [NUM_KEYS-1:0] press_m;
    logic [NUM_KEYS-1:0] lpress_m;
    logic [NUM_KEYS-1:0] srel_m;
    logic [NUM_KEYS-1:0] lrel_m;
    logic                valid_reg;
    logic [OUT_W-1:0]    data_reg;
    logic                adv;

    // Collect one bit per lane
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            press_m[i]  = evt[i].press;
            lpress_m[i] = evt[i].long_press;
            srel_m[i]   = evt[i].short_release;
            lrel_m[i]   = evt[i].long_release;
        end
    end

    // Take a new tick whenever the output slot is empty or drains this cycle
    assign in_ready = !valid_reg || out_ready;
    assign adv      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= OUT_W'({lrel_m, srel_m, lpress_m, press_m});
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/button_press_classifier.sv
// Top level of the button press classifier: config registers, key lanes,
// merge stage. Depends on bpc_pkg, bpc_lane, bpc_merge.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata: pin_levels
//  m_*       out  m_tvalid / m_tready  m_tdata: press, long_press, short_rel, long_rel
//  cfg_*     in   cfg_we               cfg_index, cfg_data
//
// One tick beat per cycle while s_tready is high; its result appears in the
// cycle after acceptance, set by the single output register in the merge stage.
// s_tready is low only while a result waits and m_tready is low.
// Reset puts every key in the released phase with a zero hold count and
// loads the register reset values.
`timescale 1ns / 1ps

module button_press_classifier #(
    parameter int NUM_KEYS = 3
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration
    input  logic                                     cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [((NUM_KEYS > 16) ? NUM_KEYS : 16)-1:0] cfg_data,
    // tick input: [NUM_KEYS-1:0] pin_levels
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((NUM_KEYS + 7) / 8) * 8 - 1:0]    s_tdata,
    // events: press_mask, long_press_mask, short_release_mask,
    // long_release_mask, NUM_KEYS bits each from the lowest bit up
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((4 * NUM_KEYS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W = ((4 * NUM_KEYS + 7) / 8) * 8;

    logic [bpc_pkg::CNT_W-1:0] long_ticks_reg;
    logic [NUM_KEYS-1:0]       active_low_reg;
    bpc_pkg::key_evt_t         evt [NUM_KEYS];
    logic                      adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg <= bpc_pkg::LONG_PRESS_TICKS_RST;
            active_low_reg <= bpc_pkg::ACTIVE_LOW_MASK_RST[NUM_KEYS-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::REG_LONG_PRESS_TICKS: long_ticks_reg <= cfg_data[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_ACTIVE_LOW_MASK:  active_low_reg <= cfg_data[NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    assign adv = s_tvalid && s_tready;

    // One lane per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        bpc_lane u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .level      (s_tdata[k]),
            .active_low (active_low_reg[k]),
            .long_ticks (long_ticks_reg),
            .evt        (evt[k])
        );
    end

    bpc_merge #(
        .NUM_KEYS (NUM_KEYS),
        .OUT_W    (OUT_W)
    ) u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: sv/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on button_press_classifier.
`timescale 1ns / 1ps

module bpc_props #(
    parameter int NUM_KEYS = 3
)
(
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      s_tvalid,
    input logic                                      s_tready,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [((4 * NUM_KEYS + 7) / 8) * 8 - 1:0] m_tdata
);

    logic [NUM_KEYS-1:0] pr;
    logic [NUM_KEYS-1:0] lp;
    logic [NUM_KEYS-1:0] sr;
    logic [NUM_KEYS-1:0] lr;

    assign pr = m_tdata[NUM_KEYS-1:0];
    assign lp = m_tdata[2*NUM_KEYS-1:NUM_KEYS];
    assign sr = m_tdata[3*NUM_KEYS-1:2*NUM_KEYS];
    assign lr = m_tdata[4*NUM_KEYS-1:3*NUM_KEYS];

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // empty output slot never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");

    // every accepted tick yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick produced no result");

    // a key reports at most one event per tick
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((pr & lp) | (pr & sr) | (pr & lr) | (lp & sr) | (lp & lr) | (sr & lr))
                     == '0)
        else $error("key reported two events in one tick");

endmodule

bind button_press_classifier bpc_props #(.NUM_KEYS(NUM_KEYS)) u_bpc_props
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/bpc_checker.sv
// Checker for the button press classifier: watches the tick, event and
// config channels, predicts each tick's event masks and compares them.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [2:0] pin_levels
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] press, [5:3] long_press, [8:6] short_release, [11:9] long_release
    input  logic [15:0]                     m_tdata,
    output int                              fail_count,
    output int                              pending_evts
);

    localparam int NKEYS = 3;

    // Packed so that press lands in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [NKEYS-1:0] long_release;
        logic [NKEYS-1:0] short_release;
        logic [NKEYS-1:0] long_press;
        logic [NKEYS-1:0] press;
    } evt_masks_t;

    // Shadow of the block's registers and per-key state
    logic [bpc_pkg::CNT_W-1:0] long_thr;
    logic [NKEYS-1:0]          low_mask;
    logic [bpc_pkg::PH_W-1:0]  key_ph   [NKEYS];
    logic [bpc_pkg::CNT_W-1:0] hold_cnt [NKEYS];

    evt_masks_t evt_q[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Advance every key by one tick and return the events it reports
    function automatic evt_masks_t classify_tick(input logic [NKEYS-1:0] lv);
        evt_masks_t ev;
        logic       down;
        ev = '0;
        for (int k = 0; k < NKEYS; k++) begin
            down = lv[k] ^ low_mask[k];
            if (down) begin
                // count stops once long; saturates at the top
                if (key_ph[k] == bpc_pkg::PH_RELEASED || key_ph[k] == bpc_pkg::PH_PUSHED) begin
                    if (hold_cnt[k] != bpc_pkg::CNT_MAX)
                        hold_cnt[k] = hold_cnt[k] + 1'b1;
                end
                if (key_ph[k] == bpc_pkg::PH_RELEASED) begin
                    if (hold_cnt[k] != '0) begin
                        ev.press[k] = 1'b1;
                        key_ph[k]   = bpc_pkg::PH_PUSHED;
                    end
                end
                else if (key_ph[k] == bpc_pkg::PH_PUSHED && hold_cnt[k] > long_thr) begin
                    ev.long_press[k] = 1'b1;
                    key_ph[k]        = bpc_pkg::PH_LONG;
                end
            end
            else if (key_ph[k] != bpc_pkg::PH_RELEASED) begin
                // any phase other than pushed acts as long
                if (key_ph[k] == bpc_pkg::PH_PUSHED)
                    ev.short_release[k] = 1'b1;
                else
                    ev.long_release[k] = 1'b1;
                key_ph[k]   = bpc_pkg::PH_RELEASED;
                hold_cnt[k] = '0;
            end
        end
        return ev;
    endfunction

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        evt_masks_t want;
        evt_masks_t got;
        if (!rst_n) begin
            long_thr = bpc_pkg::LONG_PRESS_TICKS_RST;
            low_mask = bpc_pkg::ACTIVE_LOW_MASK_RST[NKEYS-1:0];
            for (int k = 0; k < NKEYS; k++) begin
                key_ph[k]   = bpc_pkg::PH_RELEASED;
                hold_cnt[k] = '0;
            end
            evt_q.delete();
        end
        else begin
            // tick beat: predict
            if (s_tvalid && s_tready)
                evt_q.push_back(classify_tick(s_tdata[NKEYS-1:0]));

            // event beat: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[4*NKEYS-1:0];
                if (evt_q.size() == 0) begin
                    report_mismatch($sformatf("event beat %h with no tick outstanding", got));
                end
                else begin
                    want = evt_q.pop_front();
                    if (got.press !== want.press)
                        report_mismatch($sformatf("press_mask %b, expected %b",
                                                  got.press, want.press));
                    if (got.long_press !== want.long_press)
                        report_mismatch($sformatf("long_press_mask %b, expected %b",
                                                  got.long_press, want.long_press));
                    if (got.short_release !== want.short_release)
                        report_mismatch($sformatf("short_release_mask %b, expected %b",
                                                  got.short_release, want.short_release));
                    if (got.long_release !== want.long_release)
                        report_mismatch($sformatf("long_release_mask %b, expected %b",
                                                  got.long_release, want.long_release));
                end
            end

            // register writes are for the user to make only while idle; the block does not enforce it
            if (cfg_we) begin
                if (cfg_index == bpc_pkg::REG_LONG_PRESS_TICKS)
                    long_thr = cfg_data[bpc_pkg::CNT_W-1:0];
                else if (cfg_index == bpc_pkg::REG_ACTIVE_LOW_MASK)
                    low_mask = cfg_data[NKEYS-1:0];
            end
        end
        pending_evts = evt_q.size();
    end

endmodule

// File: bench/tb.sv
// Testbench top for the button press classifier: clock, reset, tick
// stimulus with random gaps, event sink with random stalls, verdict.
// Depends on bpc_pkg, button_press_classifier and bpc_checker.
`timescale 1ns / 1ps

module tb;

    localparam int NKEYS      = 3;
    localparam int MAX_WAIT   = 18;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;    // [2:0] pin_levels
    logic                          m_tvalid;
    logic                          m_tready;
    // [2:0] press, [5:3] long_press, [8:6] short_release, [11:9] long_release
    logic [15:0]                   m_tdata;

    int  fail_count;
    int  pending_evts;
    int  quiet_cycles;
    bit  steady;       // when set, neither side idles

    // per-key run generator for well-formed press/release sequences
    bit  held     [NKEYS];
    int  run_left [NKEYS];

    button_press_classifier #(.NUM_KEYS(NKEYS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bpc_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending_evts (pending_evts)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: ends a run that stops moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Event sink: random stall before each beat
    initial
    begin
        int  stall;
        bit  seen;
        m_tready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge clk);
                seen = m_tvalid;
                @(posedge clk);
            end while (!seen);
        end
    end

    // One tick beat; returns at the edge that accepts it
    task automatic send_tick(input logic [NKEYS-1:0] lv);
        int  gap;
        bit  taken;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8-NKEYS){1'b0}}, lv};
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Stop sending and let every outstanding event drain
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_evts != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_config(input logic [15:0] thr, input logic [15:0] mask_word);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= bpc_pkg::REG_LONG_PRESS_TICKS;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= bpc_pkg::REG_ACTIVE_LOW_MASK;
        cfg_data  <= mask_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random phase: mostly held/released runs per key, some raw noise
    task automatic run_phase(input int thr, input logic [NKEYS-1:0] mask, input int n_ticks);
        logic [NKEYS-1:0] lv;
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                lv = NKEYS'($urandom);
            end
            else begin
                for (int k = 0; k < NKEYS; k++) begin
                    if (run_left[k] <= 0) begin
                        held[k]     = !held[k];
                        run_left[k] = held[k] ? $urandom_range(1, thr + 4)
                                              : $urandom_range(1, 6);
                    end
                    run_left[k]--;
                    lv[k] = held[k] ^ mask[k];
                end
            end
            send_tick(lv);
        end
    endtask

    initial
    begin
        logic [NKEYS-1:0] seq [];
        int               thr;
        logic [NKEYS-1:0] mask;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        steady    = 1'b0;
        for (int k = 0; k < NKEYS; k++) begin
            held[k]     = 1'b0;
            run_left[k] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: key 0 active high, keys 1 and 2 active low
        seq = '{3'b110, 3'b111, 3'b000, 3'b110};
        foreach (seq[i]) send_tick(seq[i]);

        // Short threshold, all keys active high: press, long, both releases
        set_config(16'd2, 16'h0000);
        seq = '{3'b000, 3'b111, 3'b111, 3'b111, 3'b111, 3'b000,
                3'b001, 3'b011, 3'b110, 3'b100, 3'b000, 3'b101,
                3'b010, 3'b111, 3'b111, 3'b111, 3'b000};
        foreach (seq[i]) send_tick(seq[i]);

        // Long threshold, all active low: hold key 0 just past it, back to back
        set_config(16'd300, 16'hFFF8 | 16'd7);
        steady = 1'b1;
        for (int i = 0; i < 305; i++) send_tick(3'b110);
        send_tick(3'b111);
        steady = 1'b0;

        // Smallest threshold, all active high
        set_config(16'd1, 16'h0000);
        run_phase(1, 3'b000, 110);

        // Random settings
        for (int p = 0; p < 6; p++) begin
            thr  = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(1, 24);
            mask = NKEYS'($urandom);
            set_config(16'(thr), {13'($urandom), mask});
            steady = ($urandom_range(0, 3) == 0);
            run_phase(thr, mask, 110);
            steady = 1'b0;
        end

        drain();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
